@@ hw/rtl/htrc_pkg.sv @@
package htrc_pkg;

  // Table size must be a power of two: the slot is the low bits of the hash.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [31:0] HASH_ROWS  = 32'd73856093;
  localparam logic [31:0] HASH_COLS  = 32'd19349663;
  localparam logic [31:0] HASH_DEPTH = 32'd83492791;

  localparam int unsigned DEPTH_ALIGN = 64;
  localparam logic [31:0] DEPTH_ROUND = 32'(DEPTH_ALIGN - 1);
  localparam logic [31:0] DEPTH_MASK  = ~DEPTH_ROUND;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_STORE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0] rows;
    logic [31:0] cols;
    logic [31:0] depth_bucket;
    logic [1:0]  profile;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [15:0] threads;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] idx;
  } tbl_req_t;

endpackage

@@ hw/rtl/hashed_tuning_result_cache.sv @@
// Lookups pass through the input register, read stage and result register.
// Stores retire in the cycle after acceptance and give no result.
// Throughput: one request per cycle while the output does not stall; each
// request uses the table's single write or read port once.
// Reset clears all control state and every slot's valid bit; slot contents
// are not cleared and need no clearing pass.
module hashed_tuning_result_cache (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [31:0] rows_i,
  input  logic signed [31:0] cols_i,
  input  logic signed [31:0] depth_dim_i,
  input  logic        [1:0]  profile_code_i,
  input  logic        [15:0] thread_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [15:0] found_threads_o
);
  import htrc_pkg::*;

  // Input register
  logic               s1_valid_q;
  kind_e              s1_kind_q;
  logic signed [31:0] s1_rows_q;
  logic signed [31:0] s1_cols_q;
  logic signed [31:0] s1_depth_q;
  logic [1:0]         s1_profile_q;
  logic [15:0]        s1_threads_q;

  // Read stage
  logic   s2_valid_q;
  key_t   s2_key_q;

  // Result register
  logic        out_valid_q;
  logic [15:0] out_threads_q;
  logic [15:0] out_threads_d;

  key_t             s1_key;
  logic [IDX_W-1:0] s1_idx;
  tbl_req_t         tbl_req;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             rd_valid;
  logic             s2_hit;

  logic out_free;
  logic s2_free;
  logic s1_fire;
  logic s1_lookup_fire;
  logic in_fire;

  htrc_key u_key (
    .rows_i         (s1_rows_q),
    .cols_i         (s1_cols_q),
    .depth_dim_i    (s1_depth_q),
    .profile_code_i (s1_profile_q),
    .key_o          (s1_key),
    .idx_o          (s1_idx)
  );

  assign out_free       = !out_valid_q || out_ready_i;
  assign s2_free        = !s2_valid_q || out_free;
  // Stores retire straight from the input register.
  assign s1_fire        = s1_valid_q && (s1_kind_q == KIND_STORE || s2_free);
  assign s1_lookup_fire = s1_fire && s1_kind_q == KIND_LOOKUP;
  assign in_ready_o     = !s1_valid_q || s1_fire;
  assign in_fire        = in_valid_i && in_ready_o;

  // Drop stores of a zero count.
  assign tbl_req.wr_en = s1_fire && s1_kind_q == KIND_STORE && s1_threads_q != 16'd0;
  assign tbl_req.rd_en = s1_lookup_fire;
  assign tbl_req.idx   = s1_idx;

  assign wr_entry.key     = s1_key;
  assign wr_entry.threads = s1_threads_q;

  htrc_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  assign s2_hit        = rd_valid && rd_entry.key == s2_key_q;
  assign out_threads_d = s2_hit ? rd_entry.threads : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_lookup_fire;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q    <= kind_e'(kind_i);
      s1_rows_q    <= rows_i;
      s1_cols_q    <= cols_i;
      s1_depth_q   <= depth_dim_i;
      s1_profile_q <= profile_code_i;
      s1_threads_q <= thread_count_i;
    end
    if (s1_lookup_fire) begin
      s2_key_q <= s1_key;
    end
    if (out_free && s2_valid_q) begin
      out_threads_q <= out_threads_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_threads_o = out_threads_q;

  // A lookup leaving the input register always lands in the read stage.
  a_lookup_enters_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_lookup_fire |=> s2_valid_q)
    else $error("lookup lost between input register and read stage");

  // A read stage with room downstream must move into the result register.
  a_s2_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_free) |=> out_valid_q)
    else $error("read stage did not advance");

  // Valid slots never hold a zero count, so a hit never answers zero.
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_hit) |-> rd_entry.threads != 16'd0)
    else $error("hit on a slot holding a zero count");

endmodule

@@ hw/rtl/htrc_key.sv @@
module htrc_key (
  input  logic signed [31:0]         rows_i,
  input  logic signed [31:0]         cols_i,
  input  logic signed [31:0]         depth_dim_i,
  input  logic        [1:0]          profile_code_i,
  output htrc_pkg::key_t             key_o,
  output logic [htrc_pkg::IDX_W-1:0] idx_o
);
  import htrc_pkg::*;

  logic [31:0]      depth_u;
  logic [31:0]      bucket;
  logic [IDX_W-1:0] prod_rows;
  logic [IDX_W-1:0] prod_cols;
  logic [IDX_W-1:0] prod_depth;

  assign depth_u = depth_dim_i;

  // Round positive depths up to the alignment; the add wraps at 32 bits.
  always_comb begin
    if (depth_u == 32'd0 || depth_u[31]) begin
      bucket = depth_u;
    end else begin
      bucket = (depth_u + DEPTH_ROUND) & DEPTH_MASK;
    end
  end

  // Low product bits depend only on low operand bits.
  assign prod_rows  = IDX_W'(rows_i[IDX_W-1:0] * HASH_ROWS[IDX_W-1:0]);
  assign prod_cols  = IDX_W'(cols_i[IDX_W-1:0] * HASH_COLS[IDX_W-1:0]);
  assign prod_depth = IDX_W'(bucket[IDX_W-1:0] * HASH_DEPTH[IDX_W-1:0]);

  assign idx_o = prod_rows ^ prod_cols ^ prod_depth ^ IDX_W'(profile_code_i);

  assign key_o.rows         = rows_i;
  assign key_o.cols         = cols_i;
  assign key_o.depth_bucket = bucket;
  assign key_o.profile      = profile_code_i;

endmodule

@@ hw/rtl/htrc_table.sv @@
module htrc_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htrc_pkg::tbl_req_t  req_i,
  input  htrc_pkg::entry_t    wr_entry_i,
  output htrc_pkg::entry_t    rd_entry_o,
  output logic                rd_valid_o
);
  import htrc_pkg::*;

  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t                   rd_entry_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.idx] <= wr_entry_i;
    end
    if (req_i.rd_en) begin
      rd_entry_q <= mem_q[req_i.idx];
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule
